/* rtl/core/art_pkg.sv */
// Package for the address region table.
// Holds command, status and register index codes and the slot entry type.
// No dependencies.
package art_pkg;

   localparam int ADDR_W    = 64;
   localparam int FLAGS_W   = 16;
   localparam int LOG2_W    = 6;
   localparam int CMD_W     = 2;
   localparam int STATUS_W  = 2;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 64;

   localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
   localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd2;

   localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] ST_INVALID = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_PAGE_SIZE_MASK   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_KERNEL_FLAG_MASK = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HEAP_FLAG_MASK   = 2'd2;

   localparam logic [ADDR_W-1:0]  PAGE_SIZE_MASK_RESET   = 64'd4096;
   localparam logic [FLAGS_W-1:0] KERNEL_FLAG_MASK_RESET = 16'd1;
   localparam logic [FLAGS_W-1:0] HEAP_FLAG_MASK_RESET   = 16'd2;

   typedef struct packed {
      logic [ADDR_W-1:0]  start_addr;
      logic [ADDR_W-1:0]  end_addr;
      logic [FLAGS_W-1:0] flags;
      logic [LOG2_W-1:0]  page_log2;
   } slot_entry_type;

   typedef struct packed {
      logic load;
      logic calc1;
      logic calc2;
      logic calc3;
      logic scan_issue;
      logic commit;
   } ctrl_cmd_type;

   typedef struct packed {
      logic scan_last;
   } ctrl_status_type;

endpackage

/* rtl/core/art_channels.sv */
// Channel interfaces of the address region table.
// Carries valid, ready and the payload; depends on art_pkg.
interface art_req_if;
   logic                              valid;
   logic                              ready;
   logic [art_pkg::CMD_W-1:0]         cmd;
   logic [art_pkg::ADDR_W-1:0]        start_req;
   logic [art_pkg::ADDR_W-1:0]        extent;
   logic [art_pkg::FLAGS_W-1:0]       region_flags_in;
   logic [art_pkg::ADDR_W-1:0]        page_size_in;

   modport source (output valid, cmd, start_req, extent, region_flags_in, page_size_in,
                   input ready);
   modport sink (input valid, cmd, start_req, extent, region_flags_in, page_size_in,
                 output ready);
endinterface

interface art_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [art_pkg::STATUS_W-1:0]      status;
   logic                              found;
   logic [art_pkg::ADDR_W-1:0]        found_start;
   logic [art_pkg::ADDR_W-1:0]        found_end;
   logic [art_pkg::FLAGS_W-1:0]       found_flags;
   logic [art_pkg::ADDR_W-1:0]        found_page_size;
   logic [art_pkg::ADDR_W-1:0]        heap_low;
   logic [art_pkg::ADDR_W-1:0]        heap_high;

   modport source (output valid, status, found, found_start, found_end, found_flags,
                   found_page_size, heap_low, heap_high, input ready);
   modport sink (input valid, status, found, found_start, found_end, found_flags,
                 found_page_size, heap_low, heap_high, output ready);
endinterface

/* rtl/core/art_datapath.sv */
// Datapath of the address region table: request registers, checks, slot
// memory with valid bits, scan trackers, configuration and response registers.
// Depends on art_pkg.
module art_datapath #(
   parameter int REGION_SLOTS = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  art_pkg::ctrl_cmd_type             ctrl_cmd,
   output art_pkg::ctrl_status_type          ctrl_status,
   input  logic                              csr_write_enable,
   input  logic [art_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [art_pkg::CSR_DATA_W-1:0]    csr_write_data,
   input  logic [art_pkg::CMD_W-1:0]         cmd,
   input  logic [art_pkg::ADDR_W-1:0]        start_req,
   input  logic [art_pkg::ADDR_W-1:0]        extent,
   input  logic [art_pkg::FLAGS_W-1:0]       region_flags_in,
   input  logic [art_pkg::ADDR_W-1:0]        page_size_in,
   output logic [art_pkg::STATUS_W-1:0]      status,
   output logic                              found,
   output logic [art_pkg::ADDR_W-1:0]        found_start,
   output logic [art_pkg::ADDR_W-1:0]        found_end,
   output logic [art_pkg::FLAGS_W-1:0]       found_flags,
   output logic [art_pkg::ADDR_W-1:0]        found_page_size,
   output logic [art_pkg::ADDR_W-1:0]        heap_low,
   output logic [art_pkg::ADDR_W-1:0]        heap_high
);

   localparam int IDX_W = (REGION_SLOTS > 1) ? $clog2(REGION_SLOTS) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(REGION_SLOTS - 1);

   function automatic logic [art_pkg::LOG2_W-1:0] bit_position(
      input logic [art_pkg::ADDR_W-1:0] v);
      logic [art_pkg::LOG2_W-1:0] r;
      r = '0;
      for (int i = 0; i < art_pkg::ADDR_W; i++) begin
         if (v[i]) begin
            r = r | art_pkg::LOG2_W'(i);
         end
      end
      return r;
   endfunction

   // Configuration registers.
   logic [art_pkg::ADDR_W-1:0]  page_mask_ff;
   logic [art_pkg::FLAGS_W-1:0] kernel_mask_ff;
   logic [art_pkg::FLAGS_W-1:0] heap_mask_ff;

   // Request and check registers.
   logic [art_pkg::CMD_W-1:0]   cmd_ff;
   logic [art_pkg::ADDR_W-1:0]  start_ff;
   logic [art_pkg::ADDR_W-1:0]  extent_ff;
   logic [art_pkg::FLAGS_W-1:0] flags_ff;
   logic [art_pkg::ADDR_W-1:0]  page_ff;
   logic [art_pkg::ADDR_W-1:0]  sum_ff;
   logic [art_pkg::ADDR_W-1:0]  psz_ff;
   logic                        len_zero_ff;
   logic [art_pkg::ADDR_W-1:0]  end_ff;
   logic [art_pkg::ADDR_W-1:0]  pm1_ff;
   logic                        bad_ff;
   logic [art_pkg::LOG2_W-1:0]  log2_ff;

   // Slot storage and scan pipeline.
   art_pkg::slot_entry_type     mem [REGION_SLOTS];
   logic [REGION_SLOTS-1:0]     valid_ff;
   logic [REGION_SLOTS-1:0]     valid_in;
   logic [IDX_W-1:0]            addr_ff;
   logic                        pipe_v_ff;
   logic                        pipe_valid_ff;
   logic [IDX_W-1:0]            pipe_idx_ff;
   art_pkg::slot_entry_type     rd_entry_ff;

   // Scan trackers.
   logic                        overlap_ff;
   logic                        free_found_ff;
   logic [IDX_W-1:0]            free_idx_ff;
   logic                        hit_ff;
   logic [IDX_W-1:0]            hit_idx_ff;
   art_pkg::slot_entry_type     hit_entry_ff;

   logic [art_pkg::ADDR_W-1:0]  heap_low_ff;
   logic [art_pkg::ADDR_W-1:0]  heap_high_ff;
   logic [art_pkg::ADDR_W-1:0]  heap_low_in;
   logic [art_pkg::ADDR_W-1:0]  heap_high_in;

   logic [art_pkg::STATUS_W-1:0] status_ff;
   logic                         found_ff;
   logic [art_pkg::ADDR_W-1:0]   found_start_ff;
   logic [art_pkg::ADDR_W-1:0]   found_end_ff;
   logic [art_pkg::FLAGS_W-1:0]  found_flags_ff;
   logic [art_pkg::ADDR_W-1:0]   found_page_size_ff;

   logic                         add_ok;
   logic                         del_ok;
   logic [art_pkg::STATUS_W-1:0] status_in;
   logic                         found_in;
   logic                         slot_overlap;
   logic                         slot_cover;
   art_pkg::slot_entry_type      new_entry;

   assign ctrl_status.scan_last = (addr_ff == LAST_IDX);

   assign slot_overlap = (start_ff < rd_entry_ff.end_addr) && (end_ff > rd_entry_ff.start_addr);
   assign slot_cover   = (rd_entry_ff.start_addr <= start_ff) && (rd_entry_ff.end_addr > start_ff);

   assign new_entry.start_addr = start_ff;
   assign new_entry.end_addr   = end_ff;
   assign new_entry.flags      = flags_ff;
   assign new_entry.page_log2  = log2_ff;

   always_comb begin
      add_ok       = 1'b0;
      del_ok       = 1'b0;
      found_in     = 1'b0;
      valid_in     = valid_ff;
      heap_low_in  = heap_low_ff;
      heap_high_in = heap_high_ff;
      unique case (cmd_ff)
         art_pkg::CMD_ADD: begin
            if (bad_ff || overlap_ff) begin
               status_in = art_pkg::ST_INVALID;
            end else if (!free_found_ff) begin
               status_in = art_pkg::ST_FULL;
            end else begin
               status_in = art_pkg::ST_OK;
               add_ok    = 1'b1;
               valid_in[free_idx_ff] = 1'b1;
               if ((flags_ff & heap_mask_ff) != '0) begin
                  heap_low_in  = start_ff;
                  heap_high_in = end_ff;
               end
            end
         end
         art_pkg::CMD_DELETE: begin
            del_ok = hit_ff && (hit_entry_ff.start_addr == start_ff)
                     && (hit_entry_ff.end_addr == end_ff)
                     && ((hit_entry_ff.flags & kernel_mask_ff) == '0);
            status_in = del_ok ? art_pkg::ST_OK : art_pkg::ST_INVALID;
            if (del_ok) begin
               valid_in[hit_idx_ff] = 1'b0;
            end
         end
         art_pkg::CMD_LOOKUP: begin
            status_in = art_pkg::ST_OK;
            found_in  = hit_ff;
         end
         default: begin
            status_in = art_pkg::ST_INVALID;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         page_mask_ff   <= art_pkg::PAGE_SIZE_MASK_RESET;
         kernel_mask_ff <= art_pkg::KERNEL_FLAG_MASK_RESET;
         heap_mask_ff   <= art_pkg::HEAP_FLAG_MASK_RESET;
         valid_ff       <= '0;
         addr_ff        <= '0;
         pipe_v_ff      <= 1'b0;
         heap_low_ff    <= '0;
         heap_high_ff   <= '0;
      end else begin
         if (csr_write_enable) begin
            unique case (csr_index)
               art_pkg::CSR_PAGE_SIZE_MASK: begin
                  page_mask_ff <= csr_write_data;
               end
               art_pkg::CSR_KERNEL_FLAG_MASK: begin
                  kernel_mask_ff <= csr_write_data[art_pkg::FLAGS_W-1:0];
               end
               art_pkg::CSR_HEAP_FLAG_MASK: begin
                  heap_mask_ff <= csr_write_data[art_pkg::FLAGS_W-1:0];
               end
               default: begin
               end
            endcase
         end
         pipe_v_ff <= ctrl_cmd.scan_issue;
         if (ctrl_cmd.load) begin
            addr_ff <= '0;
         end else if (ctrl_cmd.scan_issue) begin
            addr_ff <= addr_ff + 1'b1;
         end
         if (ctrl_cmd.commit) begin
            valid_ff     <= valid_in;
            heap_low_ff  <= heap_low_in;
            heap_high_ff <= heap_high_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl_cmd.load) begin
         cmd_ff    <= cmd;
         start_ff  <= start_req;
         extent_ff <= extent;
         flags_ff  <= region_flags_in;
         page_ff   <= page_size_in;
      end
      if (ctrl_cmd.calc1) begin
         sum_ff      <= start_ff + extent_ff;
         psz_ff      <= page_ff & page_mask_ff;
         len_zero_ff <= (extent_ff == '0);
      end
      if (ctrl_cmd.calc2) begin
         end_ff <= (sum_ff == '0) ? '1 : sum_ff;
         pm1_ff <= psz_ff - 1'b1;
      end
      if (ctrl_cmd.calc3) begin
         bad_ff <= len_zero_ff || (start_ff >= end_ff) || (psz_ff == '0)
                   || ((psz_ff & pm1_ff) != '0) || ((start_ff & pm1_ff) != '0)
                   || ((end_ff != '1) && ((end_ff & pm1_ff) != '0));
         log2_ff <= bit_position(psz_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl_cmd.commit && add_ok) begin
         mem[free_idx_ff] <= new_entry;
      end
      rd_entry_ff   <= mem[addr_ff];
      pipe_valid_ff <= valid_ff[addr_ff];
      pipe_idx_ff   <= addr_ff;
   end

   always_ff @(posedge clock) begin
      if (ctrl_cmd.load) begin
         overlap_ff    <= 1'b0;
         free_found_ff <= 1'b0;
         hit_ff        <= 1'b0;
      end else if (pipe_v_ff) begin
         if (pipe_valid_ff) begin
            if (slot_overlap) begin
               overlap_ff <= 1'b1;
            end
            if (slot_cover && !hit_ff) begin
               hit_ff       <= 1'b1;
               hit_idx_ff   <= pipe_idx_ff;
               hit_entry_ff <= rd_entry_ff;
            end
         end else if (!free_found_ff) begin
            free_found_ff <= 1'b1;
            free_idx_ff   <= pipe_idx_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl_cmd.commit) begin
         status_ff          <= status_in;
         found_ff           <= found_in;
         found_start_ff     <= found_in ? hit_entry_ff.start_addr : '0;
         found_end_ff       <= found_in ? hit_entry_ff.end_addr : '0;
         found_flags_ff     <= found_in ? hit_entry_ff.flags : '0;
         found_page_size_ff <= found_in ? (art_pkg::ADDR_W'(1) << hit_entry_ff.page_log2) : '0;
      end
   end

   assign status          = status_ff;
   assign found           = found_ff;
   assign found_start     = found_start_ff;
   assign found_end       = found_end_ff;
   assign found_flags     = found_flags_ff;
   assign found_page_size = found_page_size_ff;
   assign heap_low        = heap_low_ff;
   assign heap_high       = heap_high_ff;

endmodule

/* rtl/core/art_ctrl.sv */
// Controller of the address region table: sequences checks, slot scan and
// commit, and runs the request and response handshakes. Depends on art_pkg.
module art_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   input  art_pkg::ctrl_status_type      ctrl_status,
   output art_pkg::ctrl_cmd_type         ctrl_cmd
);

   typedef enum logic [6:0] {
      S_IDLE   = 7'b0000001,
      S_CALC1  = 7'b0000010,
      S_CALC2  = 7'b0000100,
      S_CALC3  = 7'b0001000,
      S_SCAN   = 7'b0010000,
      S_DRAIN  = 7'b0100000,
      S_FINISH = 7'b1000000
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;

   always_comb begin
      state_in = state_ff;
      ctrl_cmd = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               ctrl_cmd.load = 1'b1;
               state_in = S_CALC1;
            end
         end
         S_CALC1: begin
            ctrl_cmd.calc1 = 1'b1;
            state_in = S_CALC2;
         end
         S_CALC2: begin
            ctrl_cmd.calc2 = 1'b1;
            state_in = S_CALC3;
         end
         S_CALC3: begin
            ctrl_cmd.calc3 = 1'b1;
            state_in = S_SCAN;
         end
         S_SCAN: begin
            ctrl_cmd.scan_issue = 1'b1;
            if (ctrl_status.scan_last) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            state_in = S_FINISH;
         end
         S_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               ctrl_cmd.commit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      priority if (ctrl_cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

/* rtl/core/address_region_table.sv */
// Top level of the address region table; joins controller and datapath.
// Depends on art_pkg, art_channels, art_ctrl and art_datapath.
//
// Each transaction, once accepted in the idle state, runs three steps of end
// and page-size checks, then reads one slot per cycle from the slot memory
// and compares it, waits in a drain state for the last read to land, and
// commits. The commit stalls while an earlier result is still waiting. A new
// request is taken while the previous result still waits in the output
// register. The table is empty right after reset; configuration writes take
// effect at once.
module address_region_table #(
   parameter int REGION_SLOTS = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_write_enable,
   input  logic [art_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [art_pkg::CSR_DATA_W-1:0]    csr_write_data,
   art_req_if.sink                           req_channel,
   art_rsp_if.source                         rsp_channel
);

   art_pkg::ctrl_cmd_type    ctrl_cmd;
   art_pkg::ctrl_status_type ctrl_status;

   art_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_channel.valid),
      .req_ready   (req_channel.ready),
      .rsp_valid   (rsp_channel.valid),
      .rsp_ready   (rsp_channel.ready),
      .ctrl_status (ctrl_status),
      .ctrl_cmd    (ctrl_cmd)
   );

   art_datapath #(
      .REGION_SLOTS (REGION_SLOTS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .ctrl_cmd         (ctrl_cmd),
      .ctrl_status      (ctrl_status),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cmd              (req_channel.cmd),
      .start_req        (req_channel.start_req),
      .extent           (req_channel.extent),
      .region_flags_in  (req_channel.region_flags_in),
      .page_size_in     (req_channel.page_size_in),
      .status           (rsp_channel.status),
      .found            (rsp_channel.found),
      .found_start      (rsp_channel.found_start),
      .found_end        (rsp_channel.found_end),
      .found_flags      (rsp_channel.found_flags),
      .found_page_size  (rsp_channel.found_page_size),
      .heap_low         (rsp_channel.heap_low),
      .heap_high        (rsp_channel.heap_high)
   );

endmodule

/* sim/address_region_table_tb.sv */
// Self-checking testbench for address_region_table: a directed table, then
// random add, delete, lookup and unknown-command transactions under several register settings.
// Depends on art_pkg, art_channels and the address_region_table RTL.
`timescale 1ns / 1ps

module address_region_table_tb;

   localparam int REGION_SLOTS = 16;
   localparam int CMD_LATENCY = REGION_SLOTS + 6;
   localparam int CYCLE_LIMIT = 600000;
   localparam int RANDOM_PHASES = 6;
   localparam int ITEMS_PER_PHASE = 309;
   localparam logic [art_pkg::CMD_W-1:0] CMD_UNKNOWN = 2'd3;
   localparam logic [art_pkg::ADDR_W-1:0] ALL_ONES = '1;
   localparam logic [art_pkg::ADDR_W-1:0] WINDOW_HIGH = 64'h0000_7fff_0000_0000;

   typedef struct packed {
      logic [art_pkg::CMD_W-1:0]   cmd;
      logic [art_pkg::ADDR_W-1:0]  start_req;
      logic [art_pkg::ADDR_W-1:0]  extent;
      logic [art_pkg::FLAGS_W-1:0] region_flags_in;
      logic [art_pkg::ADDR_W-1:0]  page_size_in;
   } region_cmd_type;

   typedef struct packed {
      logic [art_pkg::STATUS_W-1:0] status;
      logic                         found;
      logic [art_pkg::ADDR_W-1:0]   found_start;
      logic [art_pkg::ADDR_W-1:0]   found_end;
      logic [art_pkg::FLAGS_W-1:0]  found_flags;
      logic [art_pkg::ADDR_W-1:0]   found_page_size;
      logic [art_pkg::ADDR_W-1:0]   heap_low;
      logic [art_pkg::ADDR_W-1:0]   heap_high;
   } region_rsp_type;

   typedef struct {
      region_cmd_type c;
      bit             typed;
      region_rsp_type want;
   } directed_row_type;

   logic                           clock;
   logic                           reset;
   logic                           csr_write_enable;
   logic [art_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [art_pkg::CSR_DATA_W-1:0] csr_write_data;

   art_req_if req_bus ();
   art_rsp_if rsp_bus ();

   address_region_table #(.REGION_SLOTS(REGION_SLOTS)) dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_channel      (req_bus),
      .rsp_channel      (rsp_bus)
   );

   logic [art_pkg::ADDR_W-1:0]  page_mask_cfg = art_pkg::PAGE_SIZE_MASK_RESET;
   logic [art_pkg::FLAGS_W-1:0] kernel_mask_cfg = art_pkg::KERNEL_FLAG_MASK_RESET;
   logic [art_pkg::FLAGS_W-1:0] heap_mask_cfg = art_pkg::HEAP_FLAG_MASK_RESET;

   bit                          slot_used [REGION_SLOTS];
   logic [art_pkg::ADDR_W-1:0]  slot_lo [REGION_SLOTS];
   logic [art_pkg::ADDR_W-1:0]  slot_hi [REGION_SLOTS];
   logic [art_pkg::FLAGS_W-1:0] slot_flag [REGION_SLOTS];
   logic [art_pkg::ADDR_W-1:0]  slot_pg [REGION_SLOTS];
   logic [art_pkg::ADDR_W-1:0]  heap_lo_model = '0;
   logic [art_pkg::ADDR_W-1:0]  heap_hi_model = '0;

   region_rsp_type   pending_results [$];
   directed_row_type dir_rows [$];

   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int mismatches = 0;
   int cycle_count = 0;
   int sent_count = 0;
   int ok_count = 0;
   int invalid_count = 0;
   int full_count = 0;
   int hit_count = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic int covering_slot(input logic [art_pkg::ADDR_W-1:0] addr);
      for (int i = 0; i < REGION_SLOTS; i++) begin
         if (slot_used[i] && slot_lo[i] <= addr && slot_hi[i] > addr) return i;
      end
      return -1;
   endfunction

   function automatic region_rsp_type predict_region_result(input region_cmd_type c);
      region_rsp_type r;
      logic [art_pkg::ADDR_W-1:0] e;
      logic [art_pkg::ADDR_W-1:0] psz;
      int hit;
      int free_idx;
      r = '0;
      e = c.start_req + c.extent;
      if (e == '0) e = ALL_ONES;
      free_idx = -1;
      psz = c.page_size_in & page_mask_cfg;
      case (c.cmd)
         art_pkg::CMD_ADD: begin
            if (c.extent == '0 || c.start_req >= e) r.status = art_pkg::ST_INVALID;
            else if (psz == '0 || (psz & (psz - 1)) != '0) r.status = art_pkg::ST_INVALID;
            else if ((c.start_req & (psz - 1)) != '0) r.status = art_pkg::ST_INVALID;
            else if (e != ALL_ONES && (e & (psz - 1)) != '0) r.status = art_pkg::ST_INVALID;
            else begin
               r.status = art_pkg::ST_OK;
               for (int i = 0; i < REGION_SLOTS; i++) begin
                  if (slot_used[i]) begin
                     if (c.start_req < slot_hi[i] && e > slot_lo[i])
                        r.status = art_pkg::ST_INVALID;
                  end else if (free_idx < 0) begin
                     free_idx = i;
                  end
               end
               if (r.status == art_pkg::ST_OK && free_idx < 0) r.status = art_pkg::ST_FULL;
               if (r.status == art_pkg::ST_OK) begin
                  slot_used[free_idx] = 1'b1;
                  slot_lo[free_idx] = c.start_req;
                  slot_hi[free_idx] = e;
                  slot_flag[free_idx] = c.region_flags_in;
                  slot_pg[free_idx] = psz;
                  if ((c.region_flags_in & heap_mask_cfg) != '0) begin
                     heap_lo_model = c.start_req;
                     heap_hi_model = e;
                  end
               end
            end
         end
         art_pkg::CMD_DELETE: begin
            hit = covering_slot(c.start_req);
            if (hit < 0) r.status = art_pkg::ST_INVALID;
            else if (slot_lo[hit] != c.start_req || slot_hi[hit] != e ||
                     (slot_flag[hit] & kernel_mask_cfg) != '0) r.status = art_pkg::ST_INVALID;
            else begin
               r.status = art_pkg::ST_OK;
               slot_used[hit] = 1'b0;
            end
         end
         art_pkg::CMD_LOOKUP: begin
            r.status = art_pkg::ST_OK;
            hit = covering_slot(c.start_req);
            if (hit >= 0) begin
               r.found = 1'b1;
               r.found_start = slot_lo[hit];
               r.found_end = slot_hi[hit];
               r.found_flags = slot_flag[hit];
               r.found_page_size = slot_pg[hit];
            end
         end
         default: r.status = art_pkg::ST_INVALID;
      endcase
      r.heap_low = heap_lo_model;
      r.heap_high = heap_hi_model;
      return r;
   endfunction

   function automatic region_cmd_type random_region_cmd();
      region_cmd_type c;
      logic [art_pkg::ADDR_W-1:0] psz;
      logic [art_pkg::ADDR_W-1:0] span;
      int live [$];
      int low_bits [$];
      int all_bits [$];
      int pick;
      int roll;
      for (int i = 0; i < REGION_SLOTS; i++) begin
         if (slot_used[i]) live.push_back(i);
      end
      for (int b = 0; b < art_pkg::ADDR_W; b++) begin
         if (page_mask_cfg[b]) begin
            all_bits.push_back(b);
            if (b <= 24) low_bits.push_back(b);
         end
      end
      if (low_bits.size() != 0 && $urandom_range(9) < 8)
         psz = 64'd1 << low_bits[$urandom_range(low_bits.size() - 1)];
      else if (all_bits.size() != 0)
         psz = 64'd1 << all_bits[$urandom_range(all_bits.size() - 1)];
      else
         psz = 64'd1 << $urandom_range(63);
      c.cmd = art_pkg::CMD_LOOKUP;
      c.start_req = rand64();
      c.extent = rand64();
      c.region_flags_in = art_pkg::FLAGS_W'($urandom);
      c.page_size_in = rand64();
      roll = $urandom_range(99);
      if (roll < 5) begin
         c.cmd = art_pkg::CMD_W'($urandom_range(3));
      end else if (roll < 50) begin
         c.cmd = art_pkg::CMD_ADD;
         span = psz * $urandom_range(1, 8);
         pick = $urandom_range(99);
         if (pick < 60)
            c.start_req = (($urandom_range(1) ? WINDOW_HIGH : 64'd0) & ~(psz - 1)) +
                          psz * $urandom_range(31);
         else if (pick < 85)
            c.start_req = rand64() & ~(psz - 1);
         else if (pick < 95)
            c.start_req = 64'd0 - span;
         c.extent = span;
         if ($urandom_range(9) == 0) c.extent = $urandom_range(1) ? rand64() : 64'd0;
         if ($urandom_range(9) < 8) c.region_flags_in = c.region_flags_in & ~kernel_mask_cfg;
         case ($urandom_range(9))
            0: ;
            1, 2, 3, 4: c.page_size_in = psz | (rand64() & ~page_mask_cfg);
            default: c.page_size_in = psz;
         endcase
      end else if (roll < (live.size() > 12 ? 78 : 68)) begin
         c.cmd = art_pkg::CMD_DELETE;
         if (live.size() != 0 && $urandom_range(9) != 0) begin
            pick = live[$urandom_range(live.size() - 1)];
            c.start_req = slot_lo[pick];
            c.extent = slot_hi[pick] - slot_lo[pick];
            case ($urandom_range(9))
               0: c.extent = c.extent + 1;
               1: c.start_req = c.start_req + 1;
               2: c.extent = c.extent - slot_pg[pick];
               default: ;
            endcase
         end
      end else begin
         c.cmd = art_pkg::CMD_LOOKUP;
         if (live.size() != 0 && $urandom_range(9) < 7) begin
            pick = live[$urandom_range(live.size() - 1)];
            span = slot_hi[pick] - slot_lo[pick];
            case ($urandom_range(3))
               0: c.start_req = slot_lo[pick];
               1: c.start_req = slot_hi[pick] - 1;
               2: c.start_req = slot_hi[pick];
               default: c.start_req = slot_lo[pick] + rand64() % span;
            endcase
         end else if ($urandom_range(1)) begin
            c.start_req = ALL_ONES;
         end
      end
      return c;
   endfunction

   function automatic directed_row_type dir_row(input logic [art_pkg::CMD_W-1:0] cmd,
                                                input logic [art_pkg::ADDR_W-1:0] s,
                                                input logic [art_pkg::ADDR_W-1:0] ext,
                                                input logic [art_pkg::FLAGS_W-1:0] fl,
                                                input logic [art_pkg::ADDR_W-1:0] pg,
                                                input bit typed,
                                                input logic [art_pkg::STATUS_W-1:0] st,
                                                input logic [art_pkg::ADDR_W-1:0] hl,
                                                input logic [art_pkg::ADDR_W-1:0] hh);
      directed_row_type row;
      row.c = '{cmd, s, ext, fl, pg};
      row.typed = typed;
      row.want = '0;
      row.want.status = st;
      row.want.heap_low = hl;
      row.want.heap_high = hh;
      return row;
   endfunction

   task automatic send_cmd(input region_cmd_type c, input bit typed,
                           input region_rsp_type typed_rsp);
      region_rsp_type want;
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.cmd <= c.cmd;
      req_bus.start_req <= c.start_req;
      req_bus.extent <= c.extent;
      req_bus.region_flags_in <= c.region_flags_in;
      req_bus.page_size_in <= c.page_size_in;
      @(posedge clock);
      while (req_bus.ready !== 1'b1) @(posedge clock);
      want = predict_region_result(c);
      if (typed) want = typed_rsp;
      pending_results.push_back(want);
      sent_count++;
      case (want.status)
         art_pkg::ST_OK: ok_count++;
         art_pkg::ST_FULL: full_count++;
         default: invalid_count++;
      endcase
      if (want.found) hit_count++;
   endtask

   task automatic drain_results();
      req_bus.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   task automatic write_registers(input logic [art_pkg::ADDR_W-1:0] psm,
                                  input logic [art_pkg::FLAGS_W-1:0] km,
                                  input logic [art_pkg::FLAGS_W-1:0] hm);
      csr_write_enable <= 1'b1;
      csr_index <= art_pkg::CSR_PAGE_SIZE_MASK;
      csr_write_data <= psm;
      @(posedge clock);
      csr_index <= art_pkg::CSR_KERNEL_FLAG_MASK;
      csr_write_data <= {(art_pkg::CSR_DATA_W - art_pkg::FLAGS_W)'(rand64()), km};
      @(posedge clock);
      csr_index <= art_pkg::CSR_HEAP_FLAG_MASK;
      csr_write_data <= {(art_pkg::CSR_DATA_W - art_pkg::FLAGS_W)'(rand64()), hm};
      @(posedge clock);
      csr_write_enable <= 1'b0;
      page_mask_cfg = psm;
      kernel_mask_cfg = km;
      heap_mask_cfg = hm;
   endtask

   task automatic check_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
      if (want !== got) begin
         if (mismatches < 40)
            $display("%0t: %s expected %h actual %h", $time, name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      rsp_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   always @(posedge clock) begin : result_check
      region_rsp_type got;
      region_rsp_type want;
      if (reset === 1'b0 && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         got = {rsp_bus.status, rsp_bus.found, rsp_bus.found_start, rsp_bus.found_end,
                rsp_bus.found_flags, rsp_bus.found_page_size, rsp_bus.heap_low,
                rsp_bus.heap_high};
         if (pending_results.size() == 0) begin
            if (mismatches < 40)
               $display("%0t: result with no transaction pending, expected none actual %h",
                        $time, got);
            mismatches++;
         end else begin
            want = pending_results.pop_front();
            check_field("status", 64'(want.status), 64'(got.status));
            check_field("found", 64'(want.found), 64'(got.found));
            check_field("found_start", want.found_start, got.found_start);
            check_field("found_end", want.found_end, got.found_end);
            check_field("found_flags", 64'(want.found_flags), 64'(got.found_flags));
            check_field("found_page_size", want.found_page_size, got.found_page_size);
            check_field("heap_low", want.heap_low, got.heap_low);
            check_field("heap_high", want.heap_high, got.heap_high);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timed out with %0d results outstanding.", pending_results.size());
         $display("end of test: mismatches");
         $finish;
      end
   end

   initial begin : stimulus
      logic [art_pkg::ADDR_W-1:0] psm;
      logic [art_pkg::FLAGS_W-1:0] km;
      logic [art_pkg::FLAGS_W-1:0] hm;
      clock = 1'b0;
      reset = 1'b1;
      csr_write_enable = 1'b0;
      csr_index = art_pkg::CSR_PAGE_SIZE_MASK;
      csr_write_data = '0;
      req_bus.valid = 1'b0;
      req_bus.cmd = art_pkg::CMD_ADD;
      req_bus.start_req = '0;
      req_bus.extent = '0;
      req_bus.region_flags_in = '0;
      req_bus.page_size_in = '0;
      rsp_bus.ready = 1'b0;
      for (int i = 0; i < REGION_SLOTS; i++) begin
         slot_used[i] = 1'b0;
         slot_lo[i] = '0;
         slot_hi[i] = '0;
         slot_flag[i] = '0;
         slot_pg[i] = '0;
      end

      dir_rows.push_back(dir_row(art_pkg::CMD_LOOKUP, 64'h0, 64'h0, 16'h0, 64'h0,
                                 1'b1, art_pkg::ST_OK, 64'h0, 64'h0));
      dir_rows.push_back(dir_row(CMD_UNKNOWN, ALL_ONES, ALL_ONES, 16'hffff, ALL_ONES,
                                 1'b1, art_pkg::ST_INVALID, 64'h0, 64'h0));
      dir_rows.push_back(dir_row(art_pkg::CMD_ADD, 64'h1000, 64'h0, 16'h0, 64'h1000,
                                 1'b1, art_pkg::ST_INVALID, 64'h0, 64'h0));
      dir_rows.push_back(dir_row(art_pkg::CMD_ADD, 64'h2000, ALL_ONES, 16'h0, 64'h1000,
                                 1'b1, art_pkg::ST_INVALID, 64'h0, 64'h0));
      dir_rows.push_back(dir_row(art_pkg::CMD_ADD, 64'h1000, 64'h1000, 16'h0, ~64'h1000,
                                 1'b1, art_pkg::ST_INVALID, 64'h0, 64'h0));
      dir_rows.push_back(dir_row(art_pkg::CMD_ADD, 64'h1800, 64'h1000, 16'h0, 64'h1000,
                                 1'b1, art_pkg::ST_INVALID, 64'h0, 64'h0));
      dir_rows.push_back(dir_row(art_pkg::CMD_ADD, 64'h1000, 64'h1800, 16'h0, 64'h1000,
                                 1'b1, art_pkg::ST_INVALID, 64'h0, 64'h0));
      dir_rows.push_back(dir_row(art_pkg::CMD_ADD, 64'h10000, 64'h4000, 16'h0, 64'h1000,
                                 1'b1, art_pkg::ST_OK, 64'h0, 64'h0));
      dir_rows.push_back(dir_row(art_pkg::CMD_ADD, 64'h12000, 64'h4000, 16'h0, 64'h1000,
                                 1'b1, art_pkg::ST_INVALID, 64'h0, 64'h0));
      dir_rows.push_back(dir_row(art_pkg::CMD_ADD, 64'hffff_ffff_ffff_f000, 64'h1000, 16'h1,
                                 ALL_ONES, 1'b1, art_pkg::ST_OK, 64'h0, 64'h0));
      dir_rows.push_back(dir_row(art_pkg::CMD_LOOKUP, ALL_ONES, 64'h0, 16'h0, 64'h0,
                                 1'b1, art_pkg::ST_OK, 64'h0, 64'h0));
      dir_rows.push_back(dir_row(art_pkg::CMD_LOOKUP, ALL_ONES - 1, 64'h0, 16'h0, 64'h0,
                                 1'b0, art_pkg::ST_OK, 64'h0, 64'h0));
      dir_rows.push_back(dir_row(art_pkg::CMD_DELETE, 64'hffff_ffff_ffff_f000, 64'h1000,
                                 16'h0, 64'h0, 1'b1, art_pkg::ST_INVALID, 64'h0, 64'h0));
      dir_rows.push_back(dir_row(art_pkg::CMD_ADD, 64'h40000, 64'h8000, 16'h2, 64'h1000,
                                 1'b1, art_pkg::ST_OK, 64'h40000, 64'h48000));
      dir_rows.push_back(dir_row(art_pkg::CMD_LOOKUP, 64'h47fff, 64'h0, 16'h0, 64'h0,
                                 1'b0, art_pkg::ST_OK, 64'h0, 64'h0));
      dir_rows.push_back(dir_row(art_pkg::CMD_LOOKUP, 64'h48000, 64'h0, 16'h0, 64'h0,
                                 1'b0, art_pkg::ST_OK, 64'h0, 64'h0));
      dir_rows.push_back(dir_row(art_pkg::CMD_DELETE, 64'h10000, 64'h2000, 16'h0, 64'h0,
                                 1'b1, art_pkg::ST_INVALID, 64'h40000, 64'h48000));
      dir_rows.push_back(dir_row(art_pkg::CMD_DELETE, 64'h11000, 64'h3000, 16'h0, 64'h0,
                                 1'b1, art_pkg::ST_INVALID, 64'h40000, 64'h48000));
      dir_rows.push_back(dir_row(art_pkg::CMD_DELETE, 64'h10000, 64'h4000, 16'h0, 64'h0,
                                 1'b1, art_pkg::ST_OK, 64'h40000, 64'h48000));
      dir_rows.push_back(dir_row(art_pkg::CMD_DELETE, 64'h10000, 64'h4000, 16'h0, 64'h0,
                                 1'b1, art_pkg::ST_INVALID, 64'h40000, 64'h48000));
      dir_rows.push_back(dir_row(art_pkg::CMD_ADD, 64'h0, ALL_ONES, 16'hffff, 64'h1000,
                                 1'b1, art_pkg::ST_INVALID, 64'h40000, 64'h48000));
      dir_rows.push_back(dir_row(art_pkg::CMD_LOOKUP, 64'h40000, 64'h0, 16'h0, 64'h0,
                                 1'b0, art_pkg::ST_OK, 64'h0, 64'h0));
      dir_rows.push_back(dir_row(art_pkg::CMD_ADD, 64'h10000, 64'h4000, 16'hfffc, 64'h1000,
                                 1'b0, art_pkg::ST_OK, 64'h0, 64'h0));
      dir_rows.push_back(dir_row(art_pkg::CMD_LOOKUP, 64'h13fff, 64'h0, 16'h0, 64'h0,
                                 1'b0, art_pkg::ST_OK, 64'h0, 64'h0));

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i]) send_cmd(dir_rows[i].c, dir_rows[i].typed, dir_rows[i].want);
      drain_results();

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         case (p)
            0: begin psm = ALL_ONES; km = 16'h0000; hm = 16'hffff; end
            1: begin psm = 64'h4020_1000; km = 16'h0001; hm = 16'h0002; end
            2: begin
               psm = rand64();
               km = art_pkg::FLAGS_W'($urandom);
               hm = art_pkg::FLAGS_W'($urandom);
            end
            3: begin psm = 64'h0; km = 16'hffff; hm = 16'h0000; end
            4: begin psm = 64'h1; km = 16'h8000; hm = 16'h0001; end
            default: begin psm = 64'h8000_0000_0000_1000; km = 16'h0002; hm = 16'h0004; end
         endcase
         write_registers(psm, km, hm);
         case (p % 4)
            0: begin send_idle_pct = 0; recv_stall_pct = 0; end
            1: begin send_idle_pct = 83; recv_stall_pct = 0; end
            2: begin send_idle_pct = 0; recv_stall_pct = 83; end
            default: begin send_idle_pct = 24; recv_stall_pct = 24; end
         endcase
         repeat (ITEMS_PER_PHASE) send_cmd(random_region_cmd(), 1'b0, '0);
         drain_results();
         send_idle_pct = 0;
         recv_stall_pct = 0;
      end

      repeat (CMD_LATENCY) @(posedge clock);
      $display("Sent %0d transactions (%0d directed) under %0d register settings.",
               sent_count, dir_rows.size(), RANDOM_PHASES + 1);
      $display("Expected %0d ok, %0d invalid, %0d full, %0d lookup hits.",
               ok_count, invalid_count, full_count, hit_count);
      if (mismatches == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
